// ===== sv/x86_16_mov_instruction_decoder_unit_defines.svh =====
// Assertion macros for the MOV decoder RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef X86_16_MOV_INSTRUCTION_DECODER_UNIT_DEFINES_SVH
`define X86_16_MOV_INSTRUCTION_DECODER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define MOV_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define MOV_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MOV_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define MOV_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== sv/x86mov_pkg.sv =====
// Shared types, opcode patterns and the opcode classifier for the MOV decoder.
// No dependencies.
package x86mov_pkg;

    typedef enum logic [2:0] {
        FORM_RM_REG  = 3'd0,
        FORM_IMM_REG = 3'd1,
        FORM_IMM_RM  = 3'd2,
        FORM_MEM_ACC = 3'd3,
        FORM_ACC_MEM = 3'd4,
        FORM_BAD     = 3'd5
    } form_t;

    localparam logic [5:0] OP_RM_REG  = 6'b100010;   // 100010dw
    localparam logic [3:0] OP_IMM_REG = 4'b1011;     // 1011wreg
    localparam logic [6:0] OP_IMM_RM  = 7'b1100011;  // 1100011w
    localparam logic [6:0] OP_MEM_ACC = 7'b1010000;  // 1010000w
    localparam logic [6:0] OP_ACC_MEM = 7'b1010001;  // 1010001w

    localparam logic [1:0] MOD_MEM    = 2'b00;
    localparam logic [1:0] MOD_DISP8  = 2'b01;
    localparam logic [1:0] MOD_DISP16 = 2'b10;
    localparam logic [1:0] MOD_REG    = 2'b11;
    localparam logic [2:0] RM_DIRECT  = 3'b110;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned WORD_W = 16;

    typedef struct packed {
        logic                valid;
        logic [BYTE_W-1:0]   data;
    } beat_t;

    typedef struct packed {
        logic [2:0]          form;
        logic                bad_opcode;
        logic                dir_bit;
        logic                wide_bit;
        logic [1:0]          mode_field;
        logic [2:0]          reg_field;
        logic [2:0]          rm_field;
        logic                is_direct;
        logic [WORD_W-1:0]   displacement;
        logic [WORD_W-1:0]   immediate;
        logic [2:0]          length;
    } rec_t;

    function automatic form_t classify(input logic [BYTE_W-1:0] op);
        form_t f;
        if (op[7:2] == OP_RM_REG)
            f = FORM_RM_REG;
        else if (op[7:4] == OP_IMM_REG)
            f = FORM_IMM_REG;
        else if (op[7:1] == OP_IMM_RM)
            f = FORM_IMM_RM;
        else if (op[7:1] == OP_MEM_ACC)
            f = FORM_MEM_ACC;
        else if (op[7:1] == OP_ACC_MEM)
            f = FORM_ACC_MEM;
        else
            f = FORM_BAD;
        return f;
    endfunction

endpackage

// ===== sv/x86mov_in_stage.sv =====
// Input register for the code byte stream.
// Depends on x86mov_pkg (beat_t).
module x86mov_in_stage
    import x86mov_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] code_byte,
    input  logic              take,
    output beat_t             beat
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] data_reg;
    logic [BYTE_W-1:0] data_next;

    assign in_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
            data_next  = code_byte;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign beat.valid = valid_reg;
    assign beat.data  = data_reg;

endmodule

// ===== sv/x86mov_core.sv =====
// Decode core: instruction state registers and the per-byte field decode.
// Depends on x86mov_pkg and the assertion macro header.
`include "x86_16_mov_instruction_decoder_unit_defines.svh"

module x86mov_core
    import x86mov_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  step,
    input  beat_t beat,
    output logic  rec_valid,
    output rec_t  rec
);

    logic [2:0]        idx_reg,   idx_next;
    logic [BYTE_W-1:0] op_reg,    op_next;
    logic [BYTE_W-1:0] modrm_reg, modrm_next;
    logic [WORD_W-1:0] disp_reg,  disp_next;
    logic [WORD_W-1:0] imm_reg,   imm_next;

    logic [BYTE_W-1:0] b;
    form_t             cls;
    logic [1:0]        mod_f;
    logic [2:0]        rm_f;
    logic [2:0]        hdr;
    logic [2:0]        dlen;
    logic [2:0]        ilen;
    logic [2:0]        exp_len;
    logic [2:0]        q;
    logic [2:0]        q2;
    logic              bad;
    logic              done;

    assign b = beat.data;

    always_comb
    begin
        op_next    = op_reg;
        modrm_next = modrm_reg;
        disp_next  = disp_reg;
        imm_next   = imm_reg;
        if (idx_reg == 3'd0)
        begin
            op_next    = b;
            modrm_next = '0;
            disp_next  = '0;
            imm_next   = '0;
        end
        cls = classify(op_next);
        if (idx_reg == 3'd1 && (cls == FORM_RM_REG || cls == FORM_IMM_RM))
            modrm_next = b;

        mod_f = modrm_next[7:6];
        rm_f  = modrm_next[2:0];
        hdr   = 3'd1;
        dlen  = 3'd0;
        ilen  = 3'd0;
        case (cls)
            FORM_IMM_REG:
            begin
                ilen = op_next[3] ? 3'd2 : 3'd1;
            end
            FORM_MEM_ACC, FORM_ACC_MEM:
            begin
                dlen = 3'd2;
            end
            FORM_RM_REG, FORM_IMM_RM:
            begin
                hdr = 3'd2;
                case (mod_f)
                    MOD_MEM:    dlen = (rm_f == RM_DIRECT) ? 3'd2 : 3'd0;
                    MOD_DISP8:  dlen = 3'd1;
                    MOD_DISP16: dlen = 3'd2;
                    default:    dlen = 3'd0;
                endcase
                if (cls == FORM_IMM_RM)
                    ilen = op_next[0] ? 3'd2 : 3'd1;
            end
            default:
            begin
                hdr = 3'd1;
            end
        endcase

        // ModRM forms do not know their length until the second byte
        if (hdr == 3'd2 && idx_reg == 3'd0)
            exp_len = 3'd0;
        else
            exp_len = hdr + dlen + ilen;

        q  = idx_reg - hdr;
        q2 = q - dlen;
        if (idx_reg >= hdr)
        begin
            if (q < dlen)
            begin
                if (q == 3'd0)
                    disp_next = (dlen == 3'd1) ? {{8{b[7]}}, b} : {8'h00, b};
                else
                    disp_next = {b, disp_next[7:0]};
            end
            else
            begin
                if (q2 == 3'd0)
                    imm_next = {8'h00, b};
                else
                    imm_next = {b, imm_next[7:0]};
            end
        end

        bad  = (idx_reg == 3'd0) && (cls == FORM_BAD);
        done = bad || (exp_len != 3'd0 && ({1'b0, idx_reg} + 4'd1) >= {1'b0, exp_len});
        idx_next = done ? 3'd0 : idx_reg + 3'd1;
    end

    // result record
    always_comb
    begin
        rec              = '0;
        rec.form         = cls;
        rec.wide_bit     = op_next[0];
        rec.displacement = disp_next;
        rec.immediate    = imm_next;
        rec.length       = exp_len;
        case (cls)
            FORM_RM_REG, FORM_IMM_RM:
            begin
                rec.dir_bit    = (cls == FORM_RM_REG) ? op_next[1] : 1'b0;
                rec.mode_field = mod_f;
                rec.reg_field  = modrm_next[5:3];
                rec.rm_field   = rm_f;
                rec.is_direct  = (mod_f == MOD_MEM) && (rm_f == RM_DIRECT);
            end
            FORM_IMM_REG:
            begin
                rec.dir_bit    = 1'b1;
                rec.wide_bit   = op_next[3];
                rec.mode_field = MOD_REG;
                rec.reg_field  = op_next[2:0];
            end
            FORM_MEM_ACC, FORM_ACC_MEM:
            begin
                rec.dir_bit   = (cls == FORM_MEM_ACC);
                rec.rm_field  = RM_DIRECT;
                rec.is_direct = 1'b1;
            end
            default:
            begin
                rec            = '0;
                rec.bad_opcode = 1'b1;
                rec.length     = 3'd1;
            end
        endcase
    end

    assign rec_valid = step && done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            op_reg    <= '0;
            modrm_reg <= '0;
            disp_reg  <= '0;
            imm_reg   <= '0;
        end
        else if (step)
        begin
            idx_reg   <= idx_next;
            op_reg    <= op_next;
            modrm_reg <= modrm_next;
            disp_reg  <= disp_next;
            imm_reg   <= imm_next;
        end
    end

    `MOV_ASSERT_IMP(a_idx_range, clk, rst_n, 1'b1, idx_reg <= 3'd5, "byte index out of range")
    `MOV_ASSERT_NXT(a_done_restart, clk, rst_n, step && done, idx_reg == 3'd0, "index not reset after record")
    `MOV_ASSERT_IMP(a_op_known, clk, rst_n, idx_reg != 3'd0, classify(op_reg) != FORM_BAD, "mid-instruction with bad opcode")

endmodule

// ===== sv/x86mov_out_stage.sv =====
// Result register holding one decoded record until the consumer takes it.
// Depends on x86mov_pkg (rec_t).
module x86mov_out_stage
    import x86mov_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic load,
    input  rec_t rec_in,
    output logic space,
    output logic out_valid,
    input  logic out_ready,
    output rec_t rec_out
);

    logic valid_reg;
    logic valid_next;
    rec_t rec_reg;
    rec_t rec_next;

    assign space = !valid_reg || out_ready;

    always_comb
    begin
        rec_next   = rec_reg;
        valid_next = valid_reg && !out_ready;
        if (load)
        begin
            valid_next = 1'b1;
            rec_next   = rec_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    assign out_valid = valid_reg;
    assign rec_out   = rec_reg;

endmodule

// ===== sv/x86_16_mov_instruction_decoder_unit.sv =====
// 8086 MOV decoder: takes one instruction byte per beat and returns one decoded record
// per MOV instruction (or one error record per unrecognized opcode byte). A byte is
// accepted every cycle while the result side keeps up; each byte goes through an
// input register, one pass of field decode into the instruction state, and a result
// register; the decode step of a record's last byte loads that result register.
// A stalled result holds back the decode step; the input register still takes one
// more byte.
// Depends on x86mov_pkg, x86mov_in_stage, x86mov_core, x86mov_out_stage.
module x86_16_mov_instruction_decoder_unit
    import x86mov_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [7:0]               code_byte,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [2:0]               form,
    output logic                     bad_opcode,
    output logic                     dir_bit,
    output logic                     wide_bit,
    output logic [1:0]               mode_field,
    output logic [2:0]               reg_field,
    output logic [2:0]               rm_field,
    output logic                     is_direct,
    output logic signed [15:0]       displacement,
    output logic [15:0]              immediate,
    output logic [2:0]               length
);

    beat_t beat;
    logic  space;
    logic  step;
    logic  rec_valid;
    rec_t  rec;
    rec_t  rec_out;

    // decode advances when a byte is held and the result slot is free or draining
    assign step = beat.valid && space;

    x86mov_in_stage u_in
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .code_byte (code_byte),
        .take      (step),
        .beat      (beat)
    );

    x86mov_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .beat      (beat),
        .rec_valid (rec_valid),
        .rec       (rec)
    );

    x86mov_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (rec_valid),
        .rec_in    (rec),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .rec_out   (rec_out)
    );

    assign form         = rec_out.form;
    assign bad_opcode   = rec_out.bad_opcode;
    assign dir_bit      = rec_out.dir_bit;
    assign wide_bit     = rec_out.wide_bit;
    assign mode_field   = rec_out.mode_field;
    assign reg_field    = rec_out.reg_field;
    assign rm_field     = rec_out.rm_field;
    assign is_direct    = rec_out.is_direct;
    assign displacement = $signed(rec_out.displacement);
    assign immediate    = rec_out.immediate;
    assign length       = rec_out.length;

endmodule

// ===== tb/sv/tb_x86_16_mov_instruction_decoder_unit.sv =====
// Self-checking bench for the 8086 MOV decoder: byte beats in, decoded records out.
// Depends on x86mov_pkg and the x86_16_mov_instruction_decoder_unit RTL.
// Directed table first, then random instruction streams under four idle/stall mixes.
module tb_x86_16_mov_instruction_decoder_unit
    import x86mov_pkg::*;
;

    localparam int CLK_HALF     = 5;
    localparam int RST_CYCLES   = 12;
    localparam int PHASE_BYTES  = 481;
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_REPORTS  = 10;
    localparam int TIMEOUT      = 2_000_000;
    localparam int DIR_N        = 26;

    localparam logic [2:0] NO_FORM = 3'd0;

    localparam rec_t NO_REC  = '0;
    localparam rec_t BAD_REC = '{NO_FORM, 1'b1, 1'b0, 1'b0, 2'd0, 3'd0, 3'd0, 1'b0,
                                 16'h0000, 16'h0000, 3'd1};
    localparam rec_t DIRECT_LOAD = '{FORM_RM_REG, 1'b0, 1'b1, 1'b1, MOD_MEM, 3'd0,
                                     RM_DIRECT, 1'b1, 16'h1234, 16'h0000, 3'd4};
    localparam rec_t IMM_STORE_MAX = '{FORM_IMM_RM, 1'b0, 1'b0, 1'b1, MOD_MEM, 3'd0,
                                       RM_DIRECT, 1'b1, 16'h8000, 16'hFFFF, 3'd6};
    localparam rec_t ACC_LOAD = '{FORM_MEM_ACC, 1'b0, 1'b1, 1'b1, MOD_MEM, 3'd0,
                                  RM_DIRECT, 1'b1, 16'hFFFF, 16'h0000, 3'd3};
    localparam rec_t ACC_STORE = '{FORM_ACC_MEM, 1'b0, 1'b0, 1'b0, MOD_MEM, 3'd0,
                                   RM_DIRECT, 1'b1, 16'h0000, 16'h0000, 3'd3};

    typedef struct {
        logic [7:0] code;
        bit         typed;
        rec_t       rec;
    } dir_row_t;

    // typed rows carry a hand-written record; the rest go through the predictor
    dir_row_t dir_tab [DIR_N] = '{
        '{8'h00, 1'b1, BAD_REC},
        '{8'hFF, 1'b1, BAD_REC},
        '{8'h88, 1'b0, NO_REC}, '{8'hC1, 1'b0, NO_REC},
        '{8'h8B, 1'b0, NO_REC}, '{8'h06, 1'b0, NO_REC}, '{8'h34, 1'b0, NO_REC},
        '{8'h12, 1'b1, DIRECT_LOAD},
        '{8'h8A, 1'b0, NO_REC}, '{8'h47, 1'b0, NO_REC}, '{8'h80, 1'b0, NO_REC},
        '{8'hBF, 1'b0, NO_REC}, '{8'h00, 1'b0, NO_REC}, '{8'h80, 1'b0, NO_REC},
        '{8'hC7, 1'b0, NO_REC}, '{8'h06, 1'b0, NO_REC}, '{8'h00, 1'b0, NO_REC},
        '{8'h80, 1'b0, NO_REC}, '{8'hFF, 1'b0, NO_REC}, '{8'hFF, 1'b1, IMM_STORE_MAX},
        '{8'hA1, 1'b0, NO_REC}, '{8'hFF, 1'b0, NO_REC}, '{8'hFF, 1'b1, ACC_LOAD},
        '{8'hA2, 1'b0, NO_REC}, '{8'h00, 1'b0, NO_REC}, '{8'h00, 1'b1, ACC_STORE}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  code_byte;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  form;
    logic        bad_opcode;
    logic        dir_bit;
    logic        wide_bit;
    logic [1:0]  mode_field;
    logic [2:0]  reg_field;
    logic [2:0]  rm_field;
    logic        is_direct;
    logic signed [15:0] displacement;
    logic [15:0] immediate;
    logic [2:0]  length;

    // decoder state as the predictor sees it
    int          at_byte   = 0;
    int          instr_len = 0;
    logic [7:0]  op_q      = '0;
    logic [7:0]  modrm_q   = '0;
    logic [15:0] disp_q    = '0;
    logic [15:0] imm_q     = '0;

    rec_t        pending_recs [$];
    int          errors     = 0;
    int          n_bytes    = 0;
    int          n_records  = 0;
    int          n_bad      = 0;
    int          send_idle  = 0;
    int          recv_stall = 0;

    always #CLK_HALF clk = ~clk;

    x86_16_mov_instruction_decoder_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .code_byte    (code_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .form         (form),
        .bad_opcode   (bad_opcode),
        .dir_bit      (dir_bit),
        .wide_bit     (wide_bit),
        .mode_field   (mode_field),
        .reg_field    (reg_field),
        .rm_field     (rm_field),
        .is_direct    (is_direct),
        .displacement (displacement),
        .immediate    (immediate),
        .length       (length)
    );

    function automatic form_t form_of(input logic [7:0] op);
        form_t f;
        casez (op)
            8'b100010??: f = FORM_RM_REG;
            8'b1011????: f = FORM_IMM_REG;
            8'b1100011?: f = FORM_IMM_RM;
            8'b1010000?: f = FORM_MEM_ACC;
            8'b1010001?: f = FORM_ACC_MEM;
            default:     f = FORM_BAD;
        endcase
        return f;
    endfunction

    // advance the decoder by one byte; done is set when a record completes
    task automatic decode_byte(input logic [7:0] b, output bit done, output rec_t r);
        form_t      f;
        int         hdr;
        int         dlen;
        int         ilen;
        int         p;
        int         q;
        logic [1:0] md;
        logic [2:0] rmv;
        done = 1'b0;
        r = '0;
        p = at_byte;
        if (p == 0)
        begin
            op_q = b;
            modrm_q = '0;
            disp_q = '0;
            imm_q = '0;
            f = form_of(b);
            if (f == FORM_BAD)
            begin
                r.bad_opcode = 1'b1;
                r.length = 3'd1;
                instr_len = 0;
                done = 1'b1;
                return;
            end
        end
        else
        begin
            f = form_of(op_q);
            if (p == 1 && (f == FORM_RM_REG || f == FORM_IMM_RM))
                modrm_q = b;
        end
        md = modrm_q[7:6];
        rmv = modrm_q[2:0];

        hdr = 1;
        dlen = 0;
        ilen = 0;
        case (f)
            FORM_IMM_REG: ilen = op_q[3] ? 2 : 1;
            FORM_MEM_ACC, FORM_ACC_MEM: dlen = 2;
            default:
            begin
                hdr = 2;
                case (md)
                    MOD_MEM:    dlen = (rmv == RM_DIRECT) ? 2 : 0;
                    MOD_DISP8:  dlen = 1;
                    MOD_DISP16: dlen = 2;
                    default:    dlen = 0;
                endcase
                if (f == FORM_IMM_RM)
                    ilen = op_q[0] ? 2 : 1;
            end
        endcase
        // length stays unknown until the ModRM byte is in
        instr_len = (hdr == 2 && p == 0) ? 0 : hdr + dlen + ilen;

        if (p >= hdr)
        begin
            q = p - hdr;
            if (q < dlen)
            begin
                if (q == 0)
                    disp_q = (dlen == 1) ? {{8{b[7]}}, b} : {8'h00, b};
                else
                    disp_q[15:8] = b;
            end
            else
            begin
                q -= dlen;
                if (q == 0)
                    imm_q = {8'h00, b};
                else
                    imm_q[15:8] = b;
            end
        end

        if (instr_len != 0 && p + 1 >= instr_len)
        begin
            r.form = f;
            r.wide_bit = op_q[0];
            r.displacement = disp_q;
            r.immediate = imm_q;
            r.length = instr_len[2:0];
            if (f == FORM_RM_REG || f == FORM_IMM_RM)
            begin
                r.dir_bit = (f == FORM_RM_REG) ? op_q[1] : 1'b0;
                r.mode_field = md;
                r.reg_field = modrm_q[5:3];
                r.rm_field = rmv;
                r.is_direct = (md == MOD_MEM && rmv == RM_DIRECT);
            end
            else if (f == FORM_IMM_REG)
            begin
                r.dir_bit = 1'b1;
                r.wide_bit = op_q[3];
                r.mode_field = MOD_REG;
                r.reg_field = op_q[2:0];
            end
            else
            begin
                r.dir_bit = (f == FORM_MEM_ACC);
                r.rm_field = RM_DIRECT;
                r.is_direct = 1'b1;
            end
            at_byte = 0;
            done = 1'b1;
        end
        else
            at_byte = (p + 1) & 7;
    endtask

    // one input beat: random idle first, then hold valid until accepted
    task automatic push_byte(input logic [7:0] b, input bit typed, input rec_t typed_rec);
        bit   done;
        rec_t r;
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        code_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
        n_bytes++;
        decode_byte(b, done, r);
        if (done)
            pending_recs.push_back(typed ? typed_rec : r);
    endtask

    task automatic note_error(input string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall);

    always @(posedge clk)
    begin
        rec_t got;
        rec_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{form, bad_opcode, dir_bit, wide_bit, mode_field, reg_field, rm_field,
                    is_direct, displacement, immediate, length};
            n_records++;
            if (got.bad_opcode)
                n_bad++;
            if (pending_recs.size() == 0)
                note_error($sformatf("unexpected record %p", got));
            else
            begin
                want = pending_recs.pop_front();
                if (got !== want)
                    note_error($sformatf("record mismatch\n  exp %p\n  got %p", want, got));
            end
        end
    end

    initial
    begin
        int         ph;
        int         phase_start;
        int         k;
        int         n;
        int         cut_at;
        logic [31:0] rnd;
        logic [7:0] op;
        logic [7:0] b;
        rst_n = 1'b0;
        in_valid = 1'b0;
        code_byte = '0;
        out_ready = 1'b0;
        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            push_byte(dir_tab[i].code, dir_tab[i].typed, dir_tab[i].rec);

        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 69; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 69; end
                default: begin send_idle = 8; recv_stall = 8; end
            endcase
            phase_start = n_bytes;
            while (n_bytes - phase_start < PHASE_BYTES)
            begin
                if ($urandom_range(99) < 15)
                    push_byte(8'($urandom_range(255)), 1'b0, NO_REC);   // noise
                else
                begin
                    k = $urandom_range(4);
                    rnd = $urandom;
                    case (k)
                        0: op = {OP_RM_REG, rnd[1:0]};
                        1: op = {OP_IMM_REG, rnd[3:0]};
                        2: op = {OP_IMM_RM, rnd[0]};
                        3: op = {OP_MEM_ACC, rnd[0]};
                        default: op = {OP_ACC_MEM, rnd[0]};
                    endcase
                    // a few sequences are cut short so the next opcode lands mid-instruction
                    cut_at = ($urandom_range(99) < 8) ? $urandom_range(1, 5) : 7;
                    push_byte(op, 1'b0, NO_REC);
                    n = 1;
                    while (at_byte != 0 && n < cut_at)
                    begin
                        rnd = $urandom;
                        b = rnd[7:0];
                        if (n == 1 && (k == 0 || k == 2) && rnd[10:8] == 3'd0)
                            b = {MOD_MEM, rnd[13:11], RM_DIRECT};
                        push_byte(b, 1'b0, NO_REC);
                        n++;
                    end
                end
            end
        end
        in_valid <= 1'b0;

        while (pending_recs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d code bytes (directed table plus four idle/stall mixes);",
                 n_bytes);
        $display("checked %0d records, %0d of them bad-opcode, %0d errors.",
                 n_records, n_bad, errors);
        if (errors == 0 && pending_recs.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #TIMEOUT;
        $display("Timeout with %0d records outstanding", pending_recs.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
